/* design/wls_pkg.sv */
// ----------------------------------------------------------------------------
// wls_pkg
// Types, constants and payload structs shared by the latency statistics block.
// ----------------------------------------------------------------------------
package wls_pkg;

  localparam int unsigned DefWindow      = 16;
  localparam int unsigned DefPlayers     = 64;
  localparam int unsigned DefLatencyBits = 16;

  localparam int unsigned SlotW  = 6;
  localparam int unsigned LatW   = 16;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned CountW = 7;
  localparam int unsigned EventW = 32;

  // Operation codes
  localparam logic FuncAdd  = 1'b0;
  localparam logic FuncComp = 1'b1;

  typedef struct packed {
    logic             func;
    logic [SlotW-1:0] player_slot;
    logic [LatW-1:0]  latency_sample;
    logic [TimeW-1:0] cli_stamp;
  } wls_req_t;

  typedef struct packed {
    logic [LatW-1:0]   avg_lat;
    logic [LatW-1:0]   min_lat;
    logic [LatW-1:0]   max_lat;
    logic [LatW-1:0]   jitter;
    logic [CountW-1:0] win_cnt;
    logic [TimeW-1:0]  compensated_time;
    logic [EventW-1:0] events_compensated;
  } wls_rsp_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear;      // zero one slot table entry after reset
    logic load;       // capture request, count compensate events
    logic fetch;      // take slot table entry, write sample to ring
    logic rd_issue;   // read ring entry at index counter
    logic acc_sum;    // accumulate sum/min/max from read data
    logic acc_dev;    // accumulate deviation from read data
    logic div_start;  // start divider on sum
    logic div2_start; // start divider on deviation
    logic take_avg;   // latch quotient as average, write slot entry
    logic take_jit;   // latch quotient as jitter
    logic finish;     // build response
    logic clr_idx;    // reset index counter
  } wls_cmd_t;

  typedef struct packed {
    logic clr_last;   // clearing pass at the last slot
    logic is_comp;
    logic idx_last;   // index counter reached count-1
    logic div_done;
    logic few;        // fewer than two samples
  } wls_sts_t;

endpackage

/* design/wls_ram.sv */
// ----------------------------------------------------------------------------
// wls_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module wls_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/wls_div.sv */
// ----------------------------------------------------------------------------
// wls_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wls_div #(
  parameter int unsigned NumW = 22,
  parameter int unsigned DenW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] quo_o,
  output logic            done_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  // One shift-subtract step
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  // Quotient is complete the cycle after the last step
  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

/* design/wls_ctrl.sv */
// ----------------------------------------------------------------------------
// wls_ctrl
// Sequencer: sum pass, mean divide, deviation pass, jitter divide, respond.
// ----------------------------------------------------------------------------
module wls_ctrl
  import wls_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  input  wls_sts_t sts_i,
  output wls_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StIdle, StLoad, StSumRd, StSumWait, StDiv1, StDevRd, StDevWait, StDiv2, StDone,
    StResp, StClear
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   last_q, last_d;

  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q;
    last_d      = last_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    case (state_q)
      StClear: begin
        // Zero one slot entry per cycle after reset
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        // Accept a new request once the output stage is free or draining
        req_ready_o = !rsp_valid_q || rsp_ready_i;
        if (req_valid_i && req_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = StLoad;
        end
      end
      StLoad: begin
        cmd_o.fetch   = 1'b1;
        cmd_o.clr_idx = 1'b1;
        state_d = sts_i.is_comp ? StDone : StSumRd;
      end
      StSumRd: begin
        cmd_o.rd_issue = 1'b1;
        last_d  = sts_i.idx_last;
        state_d = StSumWait;
      end
      StSumWait: begin
        cmd_o.acc_sum = 1'b1;
        if (last_q) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv1;
        end else begin
          state_d = StSumRd;
        end
      end
      StDiv1: begin
        if (sts_i.div_done) begin
          cmd_o.take_avg = 1'b1;
          cmd_o.clr_idx  = 1'b1;
          state_d = sts_i.few ? StDone : StDevRd;
        end
      end
      StDevRd: begin
        cmd_o.rd_issue = 1'b1;
        last_d  = sts_i.idx_last;
        state_d = StDevWait;
      end
      StDevWait: begin
        cmd_o.acc_dev = 1'b1;
        if (last_q) begin
          cmd_o.div2_start = 1'b1;
          state_d = StDiv2;
        end else begin
          state_d = StDevRd;
        end
      end
      StDiv2: begin
        if (sts_i.div_done) begin
          cmd_o.take_jit = 1'b1;
          state_d = StDone;
        end
      end
      StDone: begin
        // Response register is free here: it was drained before acceptance
        cmd_o.finish = 1'b1;
        rsp_valid_d  = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      rsp_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      last_q      <= last_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  // Busy sequencer never accepts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !req_ready_o)
    else $error("request accepted while busy");
  // Response is raised only from the finishing state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == StDone)
    else $error("response raised out of sequence");
  // Finish never overwrites a pending response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |-> (!rsp_valid_q || rsp_ready_i))
    else $error("pending response overwritten");

endmodule

/* design/wls_dp.sv */
// ----------------------------------------------------------------------------
// wls_dp
// Datapath: slot table, sample ring, accumulators and shared divider.
// ----------------------------------------------------------------------------
module wls_dp
  import wls_pkg::*;
#(
  parameter int unsigned Window      = DefWindow,
  parameter int unsigned Players     = DefPlayers,
  parameter int unsigned LatencyBits = DefLatencyBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  wls_req_t req_i,
  input  wls_cmd_t cmd_i,
  output wls_sts_t sts_o,
  output wls_rsp_t rsp_o
);

  localparam int unsigned WinW   = $clog2(Window);
  localparam int unsigned FillW  = $clog2(Window + 1);
  localparam int unsigned PlW    = (Players > 1) ? $clog2(Players) : 1;
  localparam int unsigned AddrW  = PlW + WinW;
  localparam int unsigned SumW   = LatencyBits + FillW;
  localparam int unsigned TblW   = FillW + WinW + LatW;
  localparam int unsigned SlotN  = 2 ** SlotW;

  logic [EventW-1:0] events_q;
  logic [PlW-1:0]    clr_cnt_q;

  logic             func_q;
  logic [PlW-1:0]   slot_q;
  logic [TimeW-1:0] ctime_q;
  logic [LatencyBits-1:0] smp_q;
  logic [FillW-1:0] n_q;
  logic [WinW-1:0]  wnext_q;
  logic [LatW-1:0]  avg_old_q;
  logic [WinW-1:0]  idx_q;
  logic [SumW-1:0]  sum_q, dev_q;
  logic [LatencyBits-1:0] mn_q, mx_q, mean_q, jit_q;
  logic             first_q;
  wls_rsp_t         rsp_q;

  logic [PlW-1:0]         slot_map [SlotN];
  logic [PlW-1:0]         slot_in;
  logic [TblW-1:0]        tbl_rdata, tbl_wdata;
  logic [FillW-1:0]       fill_rd, fill_new;
  logic [WinW-1:0]        wpos_rd, wpos_new;
  logic [LatW-1:0]        avg_rd;
  logic [LatW-1:0]        rdata;
  logic [LatencyBits-1:0] sval, absdev;
  logic [SumW-1:0]        quo;
  logic                   div_done;

  // Fold the slot field into the table range
  for (genvar g = 0; g < SlotN; g++) begin : g_slot_map
    assign slot_map[g] = PlW'(g % Players);
  end

  assign slot_in  = slot_map[req_i.player_slot];
  assign {fill_rd, wpos_rd, avg_rd} = tbl_rdata;
  assign fill_new = (fill_rd < FillW'(Window)) ? fill_rd + 1'b1 : fill_rd;
  assign wpos_new = (wpos_rd == WinW'(Window - 1)) ? '0 : wpos_rd + 1'b1;
  assign tbl_wdata = cmd_i.clear ? '0 : {n_q, wnext_q, LatW'(quo)};
  assign sval     = LatencyBits'(rdata);
  assign absdev   = (sval >= mean_q) ? sval - mean_q : mean_q - sval;

  // Slot table: count, write position and mean per slot, read at acceptance
  wls_ram #(.Width(TblW), .Depth(2 ** PlW)) u_slot_tbl (
    .clk_i,
    .we_i   (cmd_i.clear || cmd_i.take_avg),
    .waddr_i(cmd_i.clear ? clr_cnt_q : slot_q),
    .wdata_i(tbl_wdata),
    .raddr_i(slot_in),
    .rdata_o(tbl_rdata)
  );

  // Sample ring: written after the slot entry arrives, read by pass index
  wls_ram #(.Width(LatW), .Depth(2 ** AddrW)) u_ring (
    .clk_i,
    .we_i   (cmd_i.fetch && (func_q == FuncAdd)),
    .waddr_i({slot_q, wpos_rd}),
    .wdata_i(LatW'(smp_q)),
    .raddr_i({slot_q, idx_q}),
    .rdata_o(rdata)
  );

  // Divide including the entry accumulated in the same cycle
  wls_div #(.NumW(SumW), .DenW(FillW)) u_div (
    .clk_i,
    .rst_ni,
    .start_i(cmd_i.div_start || cmd_i.div2_start),
    .num_i  (cmd_i.div_start ? sum_q + SumW'(sval) : dev_q + SumW'(absdev)),
    .den_i  (n_q),
    .quo_o  (quo),
    .done_o (div_done)
  );

  // Event counter and clearing pass index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      events_q  <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.load && (req_i.func == FuncComp)) begin
        events_q <= events_q + 1'b1;
      end
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= req_i.func;
      slot_q  <= slot_in;
      ctime_q <= req_i.cli_stamp;
      smp_q   <= LatencyBits'(req_i.latency_sample);
      sum_q   <= '0;
      dev_q   <= '0;
      jit_q   <= '0;
      first_q <= 1'b1;
    end
    if (cmd_i.fetch) begin
      n_q       <= (func_q == FuncAdd) ? fill_new : fill_rd;
      wnext_q   <= wpos_new;
      avg_old_q <= avg_rd;
    end
    if (cmd_i.clr_idx) begin
      idx_q <= '0;
    end else if (cmd_i.rd_issue) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.acc_sum) begin
      sum_q   <= sum_q + SumW'(sval);
      first_q <= 1'b0;
      mn_q    <= (first_q || sval < mn_q) ? sval : mn_q;
      mx_q    <= (first_q || sval > mx_q) ? sval : mx_q;
    end
    if (cmd_i.acc_dev) begin
      dev_q <= dev_q + SumW'(absdev);
    end
    if (cmd_i.take_avg) begin
      mean_q <= LatencyBits'(quo);
    end
    if (cmd_i.take_jit) begin
      jit_q <= LatencyBits'(quo);
    end
    if (cmd_i.finish) begin
      rsp_q.win_cnt            <= CountW'(n_q);
      rsp_q.events_compensated <= events_q;
      if (func_q == FuncComp) begin
        rsp_q.avg_lat          <= avg_old_q;
        rsp_q.min_lat          <= '0;
        rsp_q.max_lat          <= '0;
        rsp_q.jitter           <= '0;
        rsp_q.compensated_time <= ctime_q + TimeW'(avg_old_q);
      end else begin
        rsp_q.avg_lat          <= LatW'(mean_q);
        rsp_q.min_lat          <= LatW'(mn_q);
        rsp_q.max_lat          <= LatW'(mx_q);
        rsp_q.jitter           <= LatW'(jit_q);
        rsp_q.compensated_time <= '0;
      end
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == PlW'(Players - 1));
  assign sts_o.is_comp  = (func_q == FuncComp);
  assign sts_o.idx_last = (FillW'(idx_q) == n_q - 1'b1);
  assign sts_o.div_done = div_done;
  assign sts_o.few      = (n_q < FillW'(2));
  assign rsp_o          = rsp_q;

  // Window never exceeds its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (n_q <= FillW'(Window)))
    else $error("window count overflow");
  // Mean lies between min and max
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && func_q == FuncAdd) |-> (mean_q >= mn_q && mean_q <= mx_q))
    else $error("mean outside range");
  // Passes read only filled ring entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_issue |-> (FillW'(idx_q) < n_q))
    else $error("ring read beyond fill");

endmodule

/* design/windowed_latency_statistics.sv */
// ----------------------------------------------------------------------------
// windowed_latency_statistics
// Per-slot sliding window of latency samples with mean, min, max and jitter.
// ----------------------------------------------------------------------------
// Requests enter on req_valid_i/req_ready_o and carry an operation code, a
// slot, a sample and a client timestamp. Each request yields one response on
// rsp_valid_o/rsp_ready_i. An add request stores the sample in the slot ring
// and reports window statistics; a compensate request adds the slot's stored
// mean to the timestamp and counts the event.
// An add request reads its up to Window (16 by default) ring entries one at
// a time in two passes, the deviation pass skipped below two samples, and
// uses a shared divider, one quotient bit per cycle and 21 bits wide by
// default, for the mean and the jitter; a compensate request needs neither.
// One request is in flight at a time. A finished response waits in its
// output register while the receiver stalls; the next request can be taken
// as early as the cycle that response leaves. After reset a clearing pass
// zeroes all Players slot entries (64 by default), one per cycle, before
// the first request is accepted; ring entries are read only once written.
// ----------------------------------------------------------------------------
module windowed_latency_statistics
  import wls_pkg::*;
#(
  parameter int unsigned Window      = DefWindow,
  parameter int unsigned Players     = DefPlayers,
  parameter int unsigned LatencyBits = DefLatencyBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  wls_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output wls_rsp_t rsp_o
);

  wls_cmd_t cmd;
  wls_sts_t sts;

  wls_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .req_valid_i,
    .req_ready_o,
    .rsp_valid_o,
    .rsp_ready_i,
    .sts_i(sts),
    .cmd_o(cmd)
  );

  wls_dp #(
    .Window(Window), .Players(Players), .LatencyBits(LatencyBits)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .req_i,
    .cmd_i(cmd),
    .sts_o(sts),
    .rsp_o
  );

endmodule

/* verif/windowed_latency_statistics_test.sv */
// ----------------------------------------------------------------------------
// windowed_latency_statistics_test
// Self-checking bench for the per-slot latency window statistics block.
// Drives add and compensate requests, predicts every response from a model
// of the slot windows and compares each response as a whole.
// ----------------------------------------------------------------------------
module windowed_latency_statistics_test;
  import wls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Win     = DefWindow;
  localparam int unsigned Slots   = DefPlayers;
  localparam int unsigned MaxCyc  = 2000000;

  // Window model and queue of predicted responses
  class latency_window_board;
    logic [LatW-1:0]   ring [Slots][Win];
    int unsigned       fill [Slots];
    int unsigned       wpos [Slots];
    logic [LatW-1:0]   avg_mem [Slots];
    logic [EventW-1:0] evt_cnt;
    wls_rsp_t          pending_rsp [$];
    int unsigned       mismatches;
    int unsigned       checked;

    function new();
      for (int s = 0; s < Slots; s++) begin
        fill[s] = 0;
        wpos[s] = 0;
        avg_mem[s] = '0;
      end
      evt_cnt = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    // Update the slot state and queue the response this request causes
    function void note_request(wls_req_t req);
      wls_rsp_t   r;
      int unsigned s, n;
      longint unsigned sum, dev, mean, v;
      logic [LatW-1:0] mn, mx;
      r = '0;
      s = req.player_slot % Slots;
      if (req.func == FuncAdd) begin
        ring[s][wpos[s]] = req.latency_sample;
        wpos[s] = (wpos[s] + 1) % Win;
        if (fill[s] < Win) fill[s]++;
        n = fill[s];
        sum = 0;
        mn = ring[s][0];
        mx = ring[s][0];
        for (int i = 0; i < n; i++) begin
          sum += ring[s][i];
          if (ring[s][i] < mn) mn = ring[s][i];
          if (ring[s][i] > mx) mx = ring[s][i];
        end
        mean = sum / n;
        dev = 0;
        if (n >= 2) begin
          for (int i = 0; i < n; i++) begin
            v = ring[s][i];
            dev += (v >= mean) ? v - mean : mean - v;
          end
          r.jitter = LatW'(dev / n);
        end
        r.avg_lat = LatW'(mean);
        r.min_lat = mn;
        r.max_lat = mx;
        avg_mem[s] = LatW'(mean);
      end else begin
        r.avg_lat = avg_mem[s];
        r.compensated_time = req.cli_stamp + TimeW'(avg_mem[s]);
        evt_cnt = evt_cnt + 1;
        n = fill[s];
      end
      r.win_cnt = CountW'(n);
      r.events_compensated = evt_cnt;
      pending_rsp.insert(pending_rsp.size(), r);
    endfunction

    // Compare one response with the oldest prediction
    function void check_response(wls_rsp_t got);
      wls_rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
        return;
      end
      exp_rsp = pending_rsp.pop_front();
      checked++;
      if (got !== exp_rsp) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: avg %0d/%0d min %0d/%0d max %0d/%0d jit %0d/%0d",
                   exp_rsp.avg_lat, got.avg_lat,
                   exp_rsp.min_lat, got.min_lat,
                   exp_rsp.max_lat, got.max_lat,
                   exp_rsp.jitter, got.jitter);
          $display("          cnt %0d/%0d comp %h/%h evt %0d/%0d",
                   exp_rsp.win_cnt, got.win_cnt,
                   exp_rsp.compensated_time, got.compensated_time,
                   exp_rsp.events_compensated, got.events_compensated);
        end
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     req_valid_i;
  logic     req_ready_o;
  wls_req_t req_i;
  logic     rsp_valid_o;
  logic     rsp_ready_i;
  wls_rsp_t rsp_o;

  latency_window_board board;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  longint unsigned cycle_cnt;
  int unsigned adds_sent, comps_sent;

  windowed_latency_statistics u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MaxCyc) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Check accepted responses and toggle ready at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ready_i <= 1'b1;
    end else begin
      if (rsp_valid_o && rsp_ready_i) board.check_response(rsp_o);
      rsp_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Send one request, with an optional random idle gap first
  task automatic send_request(wls_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (!req_ready_o);
    board.note_request(req);
    if (req.func == FuncAdd) adds_sent++; else comps_sent++;
  endtask

  task automatic send_add(int unsigned slot, logic [LatW-1:0] smp);
    wls_req_t req;
    req = '0;
    req.func = FuncAdd;
    req.player_slot = SlotW'(slot);
    req.latency_sample = smp;
    req.cli_stamp = {$urandom, $urandom};
    send_request(req);
  endtask

  task automatic send_comp(int unsigned slot, logic [TimeW-1:0] ts);
    wls_req_t req;
    req = '0;
    req.func = FuncComp;
    req.player_slot = SlotW'(slot);
    req.latency_sample = LatW'($urandom);
    req.cli_stamp = ts;
    send_request(req);
  endtask

  // Random sample: mostly moderate values, sometimes extremes
  function automatic logic [LatW-1:0] pick_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return LatW'($urandom);
      default: return LatW'($urandom_range(400, 20));
    endcase
  endfunction

  task automatic random_phase(int unsigned items, int unsigned idle, int unsigned stall);
    int unsigned slot;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int k = 0; k < items; k++) begin
      // keep most traffic on a few slots so windows fill and wrap
      slot = ($urandom_range(3) != 0) ? $urandom_range(5) : $urandom_range(Slots - 1);
      if ($urandom_range(2) != 0) send_add(slot, pick_sample());
      else send_comp(slot, ($urandom_range(7) == 0) ? {TimeW{1'b1}} - $urandom_range(100)
                                                    : {$urandom, $urandom});
    end
  endtask

  initial begin
    board = new();
    cycle_cnt = 0;
    adds_sent = 0;
    comps_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unsampled slots, extremes, single sample, window wrap
    send_comp(Slots - 1, '0);
    send_comp(0, {TimeW{1'b1}});
    send_add(0, '1);
    send_comp(0, {TimeW{1'b1}});
    send_add(0, '0);
    send_add(Slots - 1, '0);
    send_add(7, 16'h5555);
    send_add(7, 16'haaaa);
    for (int i = 0; i < Win + 2; i++) send_add(3, LatW'(i * 4099));
    send_comp(3, 48'h0000_ffff_0000);

    random_phase(450, 0, 0);
    random_phase(450, 51, 0);
    random_phase(450, 0, 51);
    random_phase(400, 6, 6);
    req_valid_i <= 1'b0;

    // Drain outstanding responses, then a short settle
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (board.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("covered %0d add and %0d compensate requests, %0d responses checked",
             adds_sent, comps_sent, board.checked);
    $display("mismatches: %0d", board.mismatches);
    if (board.mismatches == 0 && board.pending_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
